// File: rtl/core/lcdnib_pkg.sv
`default_nettype none

package lcdnib_pkg;

    // Request codes carried on the input tuser
    typedef enum logic [2:0] {
        ACT_INSTR = 3'd0,
        ACT_DATA  = 3'd1,
        ACT_PRINT = 3'd2,
        ACT_GOTO  = 3'd3,
        ACT_CLEAR = 3'd4,
        ACT_HOME  = 3'd5,
        ACT_INIT  = 3'd6
    } action_t;

    // Configuration register indexes
    localparam logic [1:0] REG_WRAP_ENABLE       = 2'd0;
    localparam logic [1:0] REG_LINE_LENGTH       = 2'd1;
    localparam logic [1:0] REG_SECOND_LINE_START = 2'd2;

    localparam logic       WRAP_ENABLE_RST       = 1'b1;
    localparam logic [5:0] LINE_LENGTH_RST       = 6'd16;
    localparam logic [6:0] SECOND_LINE_START_RST = 7'd64;

    // Display command bytes
    localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    localparam int JOB_BYTES = 5;

    // One classified request: up to five bytes, each with its register select
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [JOB_BYTES-1:0]      rs;
        logic [2:0]                last_byte;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: rtl/core/lcdnib_front.sv
`default_nettype none

module lcdnib_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [6:0]        cfg_data,
    input  wire logic [2:0]        action,
    input  wire logic [7:0]        value,
    input  wire logic [5:0]        column,
    input  wire logic              line_select,
    input  wire logic [6:0]        cursor_address,
    output lcdnib_pkg::job_t       job,
    output logic                   job_valid
);

    logic       wrap_enable_reg;
    logic [5:0] line_length_reg;
    logic [6:0] second_line_start_reg;

    logic [7:0] line2_addr;
    logic [7:0] line2_end;
    logic [7:0] goto_addr;
    logic [6:0] goto_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_enable_reg       <= lcdnib_pkg::WRAP_ENABLE_RST;
            line_length_reg       <= lcdnib_pkg::LINE_LENGTH_RST;
            second_line_start_reg <= lcdnib_pkg::SECOND_LINE_START_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lcdnib_pkg::REG_WRAP_ENABLE:       wrap_enable_reg <= cfg_data[0];
                lcdnib_pkg::REG_LINE_LENGTH:       line_length_reg <= cfg_data[5:0];
                lcdnib_pkg::REG_SECOND_LINE_START: second_line_start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign line2_addr = lcdnib_pkg::CMD_SET_ADDR | {1'b0, second_line_start_reg};
    assign line2_end  = {1'b0, second_line_start_reg} + {2'b00, line_length_reg};
    assign goto_base  = line_select ? second_line_start_reg : 7'd0;
    assign goto_addr  = lcdnib_pkg::CMD_SET_ADDR + {1'b0, goto_base} + {2'b00, column};

    always_comb
    begin
        job       = '0;
        job_valid = 1'b1;
        unique case (lcdnib_pkg::action_t'(action))
            lcdnib_pkg::ACT_INSTR:
            begin
                job.bytes[0] = value;
            end
            lcdnib_pkg::ACT_DATA:
            begin
                job.bytes[0] = value;
                job.rs[0]    = lcdnib_pkg::RS_DATA;
            end
            lcdnib_pkg::ACT_PRINT:
            begin
                if (value == lcdnib_pkg::CHAR_NEWLINE)
                begin
                    job.bytes[0] = (cursor_address < second_line_start_reg)
                                   ? line2_addr : lcdnib_pkg::CMD_SET_ADDR;
                end
                else if (wrap_enable_reg && cursor_address == {1'b0, line_length_reg})
                begin
                    // end of first line: jump to second line, then print
                    job.bytes[0]  = line2_addr;
                    job.bytes[1]  = value;
                    job.rs[1]     = lcdnib_pkg::RS_DATA;
                    job.last_byte = 3'd1;
                end
                else if (wrap_enable_reg && {1'b0, cursor_address} == line2_end)
                begin
                    job.bytes[0]  = lcdnib_pkg::CMD_SET_ADDR;
                    job.bytes[1]  = value;
                    job.rs[1]     = lcdnib_pkg::RS_DATA;
                    job.last_byte = 3'd1;
                end
                else
                begin
                    job.bytes[0] = value;
                    job.rs[0]    = lcdnib_pkg::RS_DATA;
                end
            end
            lcdnib_pkg::ACT_GOTO:
            begin
                job.bytes[0] = goto_addr;
            end
            lcdnib_pkg::ACT_CLEAR:
            begin
                job.bytes[0] = lcdnib_pkg::CMD_CLEAR;
            end
            lcdnib_pkg::ACT_HOME:
            begin
                job.bytes[0] = lcdnib_pkg::CMD_HOME;
            end
            lcdnib_pkg::ACT_INIT:
            begin
                job.bytes[0]  = lcdnib_pkg::CMD_FUNCTION_SET;
                job.bytes[1]  = lcdnib_pkg::CMD_DISPLAY_OFF;
                job.bytes[2]  = lcdnib_pkg::CMD_CLEAR;
                job.bytes[3]  = lcdnib_pkg::CMD_ENTRY_MODE;
                job.bytes[4]  = value;
                job.last_byte = 3'd4;
            end
            default:
            begin
                // unused code: drop the request
                job_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/lcdnib_queue.sv
`default_nettype none

module lcdnib_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lcdnib_pkg::job_t  push_job,
    input  wire logic              pop,
    output lcdnib_pkg::job_t       head_job,
    output lcdnib_pkg::q_status_t  status
);

    lcdnib_pkg::job_t mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    assign head_job = mem_reg[rd_ptr_reg];
    // full, empty
    assign status   = {(count_reg == 2'd2), (count_reg == 2'd0)};

endmodule

`default_nettype wire

// File: rtl/core/lcdnib_back.sv
`default_nettype none

module lcdnib_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcdnib_pkg::job_t  head_job,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_rs,
    output logic [3:0]             out_nibble,
    output logic                   out_last
);

    logic [3:0] idx_reg;
    logic       valid_reg;
    logic       rs_reg;
    logic [3:0] nibble_reg;
    logic       last_reg;

    logic       advance;
    logic       is_last;
    logic [7:0] cur_byte;
    logic [3:0] cur_nibble;

    assign advance    = !valid_reg || out_ready;
    assign cur_byte   = head_job.bytes[idx_reg[3:1]];
    assign cur_nibble = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
    assign is_last    = idx_reg[0] && (idx_reg[3:1] == head_job.last_byte);
    assign pop        = advance && head_valid && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= head_valid;
            if (head_valid)
                idx_reg <= is_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    // output word register, refilled whenever the slot frees up
    always_ff @(posedge clk)
    begin
        if (advance && head_valid)
        begin
            rs_reg     <= head_job.rs[idx_reg[3:1]];
            nibble_reg <= cur_nibble;
            last_reg   <= is_last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rs     = rs_reg;
    assign out_nibble = nibble_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/char_lcd_nibble_sequencer_top.sv
// The nibble words of a request pass through the two-entry queue and then the output word register.
// Throughput: one nibble word per cycle while jobs are queued and m_tready is high; a request yields
// 2 to 10 words; requests are taken every cycle while the two-entry queue has room.
// Unused request codes produce no words and are dropped at the front.
// Reset: queue and output register empty; wrap_enable=1, line_length=16, second_line_start=64.
`default_nettype none

module char_lcd_nibble_sequencer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // value[7:0], column[13:8], line_select[14],
                                       // cursor_address[21:15], zero fill[23:22]
    input  wire logic [2:0]  s_tuser,  // action[2:0]
    // nibble stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // nibble[3:0], zero fill[7:4]
    output logic             m_tuser,  // reg_select[0]
    output logic             m_tlast
);

    lcdnib_pkg::job_t      front_job;
    lcdnib_pkg::job_t      head_job;
    lcdnib_pkg::q_status_t q_status;
    logic                  front_valid;
    logic                  push;
    logic                  pop;
    logic [3:0]            nibble;

    // Front: hold the configuration and turn each request into a byte job
    lcdnib_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (s_tuser),
        .value          (s_tdata[7:0]),
        .column         (s_tdata[13:8]),
        .line_select    (s_tdata[14]),
        .cursor_address (s_tdata[21:15]),
        .job            (front_job),
        .job_valid      (front_valid)
    );

    // Accept whenever the queue has room; unused codes are accepted and dropped
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready && front_valid;

    lcdnib_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back: walk the head job one nibble per word, high nibble first
    lcdnib_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_valid (!q_status.empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rs     (m_tuser),
        .out_nibble (nibble),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, nibble};

endmodule

`default_nettype wire

// File: tb/sv/char_lcd_nibble_sequencer_top_test.sv
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_top_test;

    import lcdnib_pkg::*;

    // Action code outside the defined set; the block drops it with no words
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    // Watchdog: worst case is ~270 requests x 10 words, each word held by a long sink stall, taken several times
    localparam int CYCLE_LIMIT = 600000;
    // Cycles to let pass once the last expected word is out (dropped requests at the front)
    localparam int TAIL_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 50;

    // One expected nibble word
    typedef struct {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } nibble_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_WRAP_ENABLE;
    logic [6:0]  cfg_data = 7'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;   // value[7:0], column[13:8], line_select[14],
                                    // cursor_address[21:15], zero fill[23:22]
    logic [2:0]  s_tuser = ACT_INSTR; // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // nibble[3:0], zero fill[7:4]
    logic        m_tuser;           // reg_select[0]
    logic        m_tlast;

    // Shadow copy of the configuration registers
    logic        shadow_wrap = WRAP_ENABLE_RST;
    logic [5:0]  shadow_line_len = LINE_LENGTH_RST;
    logic [6:0]  shadow_line2_start = SECOND_LINE_START_RST;

    nibble_word_t pending_words[$];

    int  fail_count = 0;
    int  words_checked = 0;
    int  requests_sent = 0;
    int  requests_dropped = 0;
    int  settings_applied = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    char_lcd_nibble_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_words.size());
            $display("** char_lcd_nibble_sequencer_top: FAILED **");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Split one byte into two words, high nibble first
    function automatic void push_byte(ref nibble_word_t run[$], input logic [7:0] b,
                                      input logic rs);
        nibble_word_t w;
        w.rs   = rs;
        w.last = 1'b0;
        w.nib  = b[7:4];
        run.push_back(w);
        w.nib  = b[3:0];
        run.push_back(w);
    endfunction

    // Work out the word run of one request under the current shadow configuration
    function automatic void predict_request(input logic [2:0] act, input logic [7:0] val,
                                            input logic [5:0] col, input logic ln,
                                            input logic [6:0] cur);
        nibble_word_t run[$];
        logic [7:0]   addr;
        logic [7:0]   line2_cmd;
        int           line2_end;
        line2_cmd = CMD_SET_ADDR | {1'b0, shadow_line2_start};
        line2_end = int'(shadow_line2_start) + int'(shadow_line_len);
        case (act)
            ACT_INSTR: push_byte(run, val, RS_INSTR);
            ACT_DATA:  push_byte(run, val, RS_DATA);
            ACT_PRINT:
            begin
                if (val == CHAR_NEWLINE)
                begin
                    // newline jumps to the other line, no character goes out
                    if (cur < shadow_line2_start)
                        push_byte(run, line2_cmd, RS_INSTR);
                    else
                        push_byte(run, CMD_SET_ADDR, RS_INSTR);
                end
                else
                begin
                    // line end on either line: reposition before the character
                    if (shadow_wrap)
                    begin
                        if (int'(cur) == int'(shadow_line_len))
                            push_byte(run, line2_cmd, RS_INSTR);
                        else if (int'(cur) == line2_end)
                            push_byte(run, CMD_SET_ADDR, RS_INSTR);
                    end
                    push_byte(run, val, RS_DATA);
                end
            end
            ACT_GOTO:
            begin
                // 8-bit sum wraps past the address range
                addr = CMD_SET_ADDR + (ln ? {1'b0, shadow_line2_start} : 8'd0) + {2'b00, col};
                push_byte(run, addr, RS_INSTR);
            end
            ACT_CLEAR: push_byte(run, CMD_CLEAR, RS_INSTR);
            ACT_HOME:  push_byte(run, CMD_HOME, RS_INSTR);
            ACT_INIT:
            begin
                push_byte(run, CMD_FUNCTION_SET, RS_INSTR);
                push_byte(run, CMD_DISPLAY_OFF, RS_INSTR);
                push_byte(run, CMD_CLEAR, RS_INSTR);
                push_byte(run, CMD_ENTRY_MODE, RS_INSTR);
                push_byte(run, val, RS_INSTR);
            end
            default: ;
        endcase
        if (run.size() > 0)
        begin
            run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                pending_words.push_back(run[i]);
        end
    endfunction

    // Offer one request word, hold it until accepted, then maybe idle.
    // Valid stays high into the next request when no gap is drawn.
    task automatic send_request(input logic [2:0] act, input logic [7:0] val,
                                input logic [5:0] col, input logic ln, input logic [6:0] cur);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, cur, ln, col, val};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(act, val, col, ln, cur);
        if (act == ACT_UNUSED)
            requests_dropped++;
        else
            requests_sent++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every expected word is out, plus a short tail
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back while the block is idle
    task automatic apply_config(input logic wrap, input logic [5:0] len, input logic [6:0] l2);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= REG_WRAP_ENABLE;
        cfg_data  <= {6'd0, wrap};
        @(posedge clk);
        cfg_index <= REG_LINE_LENGTH;
        cfg_data  <= {1'b0, len};
        @(posedge clk);
        cfg_index <= REG_SECOND_LINE_START;
        cfg_data  <= l2;
        @(posedge clk);
        cfg_write <= 1'b0;
        shadow_wrap        = wrap;
        shadow_line_len    = len;
        shadow_line2_start = l2;
        settings_applied++;
        @(posedge clk);
    endtask

    // One random request; printing dominates, with cursors aimed at line ends
    task automatic send_random_request();
        logic [2:0] act;
        logic [7:0] val;
        logic [6:0] cur;
        int         r;
        int         pick;
        r   = $urandom_range(0, 99);
        val = 8'($urandom_range(0, 255));
        cur = 7'($urandom_range(0, 127));
        if (r < 45)
        begin
            act  = ACT_PRINT;
            pick = $urandom_range(0, 4);
            case (pick)
                0: cur = {1'b0, shadow_line_len};
                1: cur = shadow_line2_start + {1'b0, shadow_line_len};
                2: cur = {1'b0, shadow_line_len} + 7'($urandom_range(0, 2)) - 7'd1;
                default: ;
            endcase
            if (val == CHAR_NEWLINE)
                val = 8'h41;
        end
        else if (r < 55)
        begin
            act = ACT_PRINT;
            val = CHAR_NEWLINE;
            if ($urandom_range(0, 1))
                cur = shadow_line2_start + 7'($urandom_range(0, 2)) - 7'd1;
        end
        else if (r < 69)
            act = ACT_GOTO;
        else if (r < 74)
            act = ACT_INSTR;
        else if (r < 79)
            act = ACT_DATA;
        else if (r < 84)
            act = ACT_CLEAR;
        else if (r < 89)
            act = ACT_HOME;
        else if (r < 96)
            act = ACT_INIT;
        else
            act = ACT_UNUSED;
        send_request(act, val, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), cur);
    endtask

    // Every request kind at the reset configuration, field extremes included
    task automatic test_requests_at_reset();
        send_request(ACT_INSTR, 8'h00, 6'd0, 1'b0, 7'd0);
        send_request(ACT_INSTR, 8'hFF, 6'd63, 1'b1, 7'd127);
        send_request(ACT_DATA, 8'h00, 6'd0, 1'b0, 7'd0);
        send_request(ACT_DATA, 8'hFF, 6'd63, 1'b1, 7'd127);
        send_request(ACT_PRINT, 8'h48, 6'd0, 1'b0, 7'd3);
        send_request(ACT_PRINT, 8'h48, 6'd0, 1'b0, 7'd16);    // end of first line
        send_request(ACT_PRINT, 8'h49, 6'd0, 1'b0, 7'd80);    // end of second line
        send_request(ACT_PRINT, CHAR_NEWLINE, 6'd0, 1'b0, 7'd63);
        send_request(ACT_PRINT, CHAR_NEWLINE, 6'd0, 1'b0, 7'd64);
        send_request(ACT_GOTO, 8'h00, 6'd0, 1'b0, 7'd0);
        send_request(ACT_GOTO, 8'h00, 6'd39, 1'b1, 7'd0);
        send_request(ACT_GOTO, 8'h00, 6'd63, 1'b1, 7'd0);     // address sum lands on 0xFF
        send_request(ACT_CLEAR, 8'hA5, 6'd0, 1'b0, 7'd0);
        send_request(ACT_HOME, 8'h5A, 6'd0, 1'b0, 7'd0);
        send_request(ACT_INIT, 8'h0C, 6'd0, 1'b0, 7'd0);
        send_request(ACT_UNUSED, 8'hFF, 6'd63, 1'b1, 7'd127); // dropped, no words
        send_request(ACT_INIT, 8'hFF, 6'd0, 1'b0, 7'd0);
    endtask

    // Line-end handling and goto overflow at the register extremes
    task automatic test_line_end_extremes();
        // wrap off: a character at the line end goes out alone
        apply_config(1'b0, 6'd40, 7'd0);
        send_request(ACT_PRINT, 8'h7E, 6'd0, 1'b0, 7'd40);
        send_request(ACT_PRINT, CHAR_NEWLINE, 6'd0, 1'b0, 7'd0);  // never below line 2 start
        // second line at 0: both line-end tests hold, the first one wins
        apply_config(1'b1, 6'd40, 7'd0);
        send_request(ACT_PRINT, 8'h7E, 6'd0, 1'b0, 7'd40);
        // line length 0 makes address 0 a line end
        apply_config(1'b1, 6'd0, 7'd127);
        send_request(ACT_PRINT, 8'h30, 6'd0, 1'b0, 7'd0);
        send_request(ACT_PRINT, 8'h31, 6'd0, 1'b0, 7'd127);
        // goto sum wraps modulo 256
        send_request(ACT_GOTO, 8'h00, 6'd63, 1'b1, 7'd0);
        // sum of start and length above 127 never matches
        apply_config(1'b1, 6'd63, 7'd127);
        send_request(ACT_PRINT, 8'h32, 6'd0, 1'b0, 7'd126);
        send_request(ACT_PRINT, 8'h33, 6'd0, 1'b0, 7'd63);
        apply_config(1'b1, 6'd1, 7'd20);
        send_request(ACT_PRINT, 8'h34, 6'd0, 1'b0, 7'd21);
        send_request(ACT_PRINT, CHAR_NEWLINE, 6'd0, 1'b0, 7'd20);
    endtask

    // Random traffic over several register settings, with one full drain mid-phase
    task automatic test_random_traffic();
        int target;
        int phase_start;
        logic [5:0] len_pick[4];
        len_pick = '{6'd0, 6'd1, 6'd40, 6'd63};
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: apply_config(1'b1, 6'($urandom_range(1, 40)), 7'($urandom_range(0, 127)));
                1: apply_config(1'b0, 6'($urandom_range(1, 40)), 7'($urandom_range(0, 127)));
                2: apply_config(1'($urandom_range(0, 1)), len_pick[2'($urandom_range(0, 3))],
                                $urandom_range(0, 1) ? 7'd127 : 7'd0);
                default: apply_config(WRAP_ENABLE_RST, LINE_LENGTH_RST, SECOND_LINE_START_RST);
            endcase
            phase_start = requests_sent;
            target = phase_start + RANDOM_PER_PHASE;
            while (requests_sent < target)
            begin
                send_random_request();
                // pause the sender once until the block has emptied
                if (phase == 1 && requests_sent == phase_start + RANDOM_PER_PHASE / 2)
                    wait_drained();
            end
        end
    endtask

    // Back-to-back requests with the sink always ready
    task automatic test_full_rate();
        wait_drained();
        no_idle = 1'b1;
        for (int i = 0; i < 25; i++)
            send_random_request();
        for (int i = 0; i < 5; i++)
            send_request(ACT_INIT, 8'($urandom_range(0, 255)), 6'd0, 1'b0, 7'd0);
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Sink pacing: runs of ready and stalls of random length, off while no_idle is set
    initial
    begin : sink_pacing
        int  hold;
        bit  ready_run;
        hold = 0;
        ready_run = 1'b0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
            begin
                m_tready <= 1'b1;
                hold = 0;
            end
            else
            begin
                if (hold == 0)
                begin
                    ready_run = !ready_run;
                    hold = ready_run ? $urandom_range(1, 12) : pick_gap() + 1;
                end
                m_tready <= ready_run;
                hold--;
            end
        end
    end

    // Compare each accepted nibble word against the oldest expectation
    always @(posedge clk)
    begin : word_checker
        nibble_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: reg_select=%0b nibble=%h last=%0b",
                       m_tuser, m_tdata[3:0], m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (m_tuser !== want.rs)
                begin
                    $error("reg_select: expected %0b, got %0b", want.rs, m_tuser);
                    fail_count++;
                end
                if (m_tdata[3:0] !== want.nib)
                begin
                    $error("nibble: expected %h, got %h", want.nib, m_tdata[3:0]);
                    fail_count++;
                end
                if (m_tdata[7:4] !== 4'h0)
                begin
                    $error("zero fill: expected 0, got %h", m_tdata[7:4]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        // hold reset low, then release at an edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_requests_at_reset();
        test_line_end_extremes();
        test_full_rate();
        test_random_traffic();

        wait_drained();
        if (pending_words.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_words.size());
            fail_count++;
        end

        $display("Ran %0d requests and %0d unused codes over %0d register settings;",
                 requests_sent, requests_dropped, settings_applied);
        $display("checked %0d nibble words with random stalls on both streams.", words_checked);
        if (fail_count == 0)
            $display("** char_lcd_nibble_sequencer_top: PASSED **");
        else
            $display("** char_lcd_nibble_sequencer_top: FAILED **");
        $finish;
    end

endmodule
